@@ design/lcd_csm_pkg.sv @@
// Shared types and constants for the 14-segment LCD character segment mapper.
// Holds the command codes, the glyph table and the digit bit-position map.
// No dependencies.
`default_nettype none

package lcd_csm_pkg;

   localparam int COMMONS       = 4;
   localparam int WORD_BITS     = 32;
   localparam int MASK_BITS     = 16;
   localparam int POS_BITS      = 5;
   localparam logic [2:0] LAST_POSITION = 3'd5;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_CHAR  = 2'd1,
      CMD_RAW   = 2'd2
   } command_type;

   typedef logic [COMMONS-1:0][WORD_BITS-1:0] seg_ram_type;

   // One resolved update, passed from the decoder to the placement logic.
   typedef struct packed {
      logic                 clear_all;
      logic                 write;
      logic                 digit_clear;
      logic [2:0]           position;
      logic [MASK_BITS-1:0] mask;
   } seg_update_type;

   // The four bit positions a digit occupies inside every common word.
   typedef struct packed {
      logic [POS_BITS-1:0] p1;
      logic [POS_BITS-1:0] p2;
      logic [POS_BITS-1:0] p3;
      logic [POS_BITS-1:0] p4;
   } digit_pos_type;

   function automatic digit_pos_type digit_positions(input logic [2:0] position);
      digit_pos_type result;
      unique case (position)
         3'd0:    result = '{p1: 5'd0,  p2: 5'd1,  p3: 5'd29, p4: 5'd28};
         3'd1:    result = '{p1: 5'd2,  p2: 5'd7,  p3: 5'd27, p4: 5'd26};
         3'd2:    result = '{p1: 5'd8,  p2: 5'd9,  p3: 5'd25, p4: 5'd24};
         3'd3:    result = '{p1: 5'd10, p2: 5'd11, p3: 5'd21, p4: 5'd20};
         3'd4:    result = '{p1: 5'd12, p2: 5'd13, p3: 5'd19, p4: 5'd18};
         3'd5:    result = '{p1: 5'd14, p2: 5'd15, p3: 5'd16, p4: 5'd17};
         default: result = '0;
      endcase
      return result;
   endfunction

   // Glyph table: segment mask for each ASCII code. Codes without a glyph are zero.
   function automatic logic [MASK_BITS-1:0] glyph_lookup(input logic [6:0] code);
      logic [MASK_BITS-1:0] glyph;
      unique case (code)
         7'h2A:   glyph = 16'h3FC0;
         7'h2B:   glyph = 16'h1540;
         7'h2D:   glyph = 16'h0440;
         7'h2E:   glyph = 16'h4000;
         7'h2F:   glyph = 16'h2200;
         7'h30:   glyph = 16'h003F;
         7'h31:   glyph = 16'h0006;
         7'h32:   glyph = 16'h045B;
         7'h33:   glyph = 16'h044F;
         7'h34:   glyph = 16'h0466;
         7'h35:   glyph = 16'h046D;
         7'h36:   glyph = 16'h047D;
         7'h37:   glyph = 16'h2201;
         7'h38:   glyph = 16'h047F;
         7'h39:   glyph = 16'h046F;
         7'h3A:   glyph = 16'h8000;
         7'h41:   glyph = 16'h0477;
         7'h42:   glyph = 16'h047C;
         7'h43:   glyph = 16'h0039;
         7'h44:   glyph = 16'h045E;
         7'h45:   glyph = 16'h0479;
         7'h46:   glyph = 16'h0471;
         7'h47:   glyph = 16'h043D;
         7'h48:   glyph = 16'h0476;
         7'h49:   glyph = 16'h1109;
         7'h4A:   glyph = 16'h001E;
         7'h4B:   glyph = 16'h1B00;
         7'h4C:   glyph = 16'h0038;
         7'h4D:   glyph = 16'h02B6;
         7'h4E:   glyph = 16'h08B6;
         7'h4F:   glyph = 16'h003F;
         7'h50:   glyph = 16'h0473;
         7'h51:   glyph = 16'h0467;
         7'h52:   glyph = 16'h0C73;
         7'h53:   glyph = 16'h046D;
         7'h54:   glyph = 16'h1101;
         7'h55:   glyph = 16'h003E;
         7'h56:   glyph = 16'h0886;
         7'h57:   glyph = 16'h2836;
         7'h58:   glyph = 16'h2A80;
         7'h59:   glyph = 16'h1280;
         7'h5A:   glyph = 16'h2209;
         7'h5C:   glyph = 16'h0880;
         7'h5F:   glyph = 16'h0008;
         default: glyph = 16'h0000;
      endcase
      return glyph;
   endfunction

endpackage

`default_nettype wire

@@ design/lcd_csm_decode.sv @@
// Command decoder: turns one registered request into a resolved segment update.
// Depends on lcd_csm_pkg for the command codes and the glyph table.
`default_nettype none

module lcd_csm_decode
   import lcd_csm_pkg::*;
#(
   parameter int GLYPH_ENTRIES = 96
) (
   input  wire logic [1:0]           command,
   input  wire logic [2:0]           position,
   input  wire logic [7:0]           symbol,
   input  wire logic [MASK_BITS-1:0] mask,
   input  wire logic                 digit_clear,
   output seg_update_type            update
);

   logic position_ok;
   logic symbol_ok;

   assign position_ok = (position <= LAST_POSITION);
   assign symbol_ok   = ({1'b0, symbol} < 9'(GLYPH_ENTRIES));

   always_comb begin
      update             = '0;
      update.digit_clear = digit_clear;
      update.position    = position;
      unique case (command)
         CMD_CLEAR: begin
            update.clear_all = 1'b1;
         end
         CMD_CHAR: begin
            update.write = position_ok && symbol_ok;
            update.mask  = glyph_lookup(symbol[6:0]);
         end
         CMD_RAW: begin
            update.write = position_ok;
            update.mask  = mask;
         end
         default: begin
            update.write = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/lcd_csm_place.sv @@
// Segment placement: applies one resolved update to the four common words.
// Depends on lcd_csm_pkg for the update struct and the digit position map.
`default_nettype none

module lcd_csm_place
   import lcd_csm_pkg::*;
(
   input  wire seg_update_type update,
   input  wire seg_ram_type    ram_now,
   output seg_ram_type         ram_next
);

   function automatic logic [WORD_BITS-1:0] place_bit(input logic b,
                                                      input logic [POS_BITS-1:0] p);
      return WORD_BITS'(b) << p;
   endfunction

   digit_pos_type        pos;
   logic [WORD_BITS-1:0] digit_bits;
   logic [MASK_BITS-1:0] m;
   seg_ram_type          base;
   seg_ram_type          bits;

   assign pos = digit_positions(update.position);
   assign m   = update.mask;

   assign digit_bits = place_bit(1'b1, pos.p1) | place_bit(1'b1, pos.p2)
                     | place_bit(1'b1, pos.p3) | place_bit(1'b1, pos.p4);

   // Each common carries four of the sixteen segments of the digit.
   assign bits[0] = place_bit(m[1],  pos.p4) | place_bit(m[4],  pos.p1)
                  | place_bit(m[6],  pos.p3) | place_bit(m[10], pos.p2);
   assign bits[1] = place_bit(m[0],  pos.p4) | place_bit(m[2],  pos.p2)
                  | place_bit(m[3],  pos.p1) | place_bit(m[5],  pos.p3);
   assign bits[2] = place_bit(m[9],  pos.p4) | place_bit(m[12], pos.p1)
                  | place_bit(m[13], pos.p3) | place_bit(m[15], pos.p2);
   assign bits[3] = place_bit(m[7],  pos.p3) | place_bit(m[8],  pos.p4)
                  | place_bit(m[11], pos.p1) | place_bit(m[14], pos.p2);

   always_comb begin
      for (int c = 0; c < COMMONS; c++) begin
         base[c] = update.digit_clear ? (ram_now[c] & ~digit_bits) : ram_now[c];
      end
      priority if (update.clear_all) begin
         ram_next = '0;
      end else if (update.write) begin
         for (int c = 0; c < COMMONS; c++) begin
            ram_next[c] = base[c] | bits[c];
         end
      end else begin
         ram_next = ram_now;
      end
   end

endmodule

`default_nettype wire

@@ design/lcd_char_segment_mapper.sv @@
// Top level of the 14-segment LCD character segment mapper.
// Depends on lcd_csm_pkg, lcd_csm_decode and lcd_csm_place.
//
// The block keeps the segment RAM of a six-digit 14-segment LCD: one 32-bit
// word for each of four commons. Each request transfer on the req_ channel
// carries a command (clear all, write an ASCII character, write a raw mask),
// a digit position, a symbol, a mask and a digit-clear flag. Each request
// produces exactly one response transfer on the rsp_ channel carrying all
// four common words as they stand after that request.
//
// A request is registered at its transfer. Once it is held and the response slot
// is free, the glyph lookup, bounds checks and read-modify-write of the four words
// happen in one pass of logic and load the segment RAM register, which doubles as
// the response register. rsp_valid thus rises after the input register and the RAM
// register, and the block sustains one item per clock as long as the receiver does
// not stall; the single pass through the RAM update sets that figure.
//
// While rsp_stall is high with a response waiting, the RAM holds still so the
// response stays stable; one more request may be taken into the input
// register, after which req_stall is raised. Reset clears the segment RAM to
// zeros and empties both registers.
`default_nettype none

module lcd_char_segment_mapper
   import lcd_csm_pkg::*;
#(
   parameter int GLYPH_ENTRIES = 96
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [2:0]  req_position,
   input  wire logic [7:0]  req_symbol,
   input  wire logic [15:0] req_mask,
   input  wire logic        req_digit_clear,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_com0_word,
   output logic [31:0]      rsp_com1_word,
   output logic [31:0]      rsp_com2_word,
   output logic [31:0]      rsp_com3_word
);

   // Input register.
   logic        hold_valid_ff, hold_valid_in;
   logic [1:0]  command_ff;
   logic [2:0]  position_ff;
   logic [7:0]  symbol_ff;
   logic [15:0] mask_ff;
   logic        digit_clear_ff;

   // Segment RAM, also serving as the response register.
   seg_ram_type ram_ff, ram_in;
   logic        rsp_valid_ff, rsp_valid_in;

   seg_update_type update;
   seg_ram_type    ram_next;
   logic           advance;
   logic           req_take;

   // The held request moves into the RAM whenever the response slot is free
   // or is being emptied in this cycle.
   assign advance   = hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = hold_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   lcd_csm_decode #(
      .GLYPH_ENTRIES(GLYPH_ENTRIES)
   ) u_decode (
      .command     (command_ff),
      .position    (position_ff),
      .symbol      (symbol_ff),
      .mask        (mask_ff),
      .digit_clear (digit_clear_ff),
      .update      (update)
   );

   lcd_csm_place u_place (
      .update   (update),
      .ram_now  (ram_ff),
      .ram_next (ram_next)
   );

   always_comb begin
      hold_valid_in = req_take || (hold_valid_ff && !advance);
      ram_in        = advance ? ram_next : ram_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         ram_ff        <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         ram_ff        <= ram_in;
      end
   end

   // Request payload needs no reset; it is only used while hold_valid_ff is set.
   always_ff @(posedge clock) begin
      if (req_take) begin
         command_ff     <= req_command;
         position_ff    <= req_position;
         symbol_ff      <= req_symbol;
         mask_ff        <= req_mask;
         digit_clear_ff <= req_digit_clear;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_com0_word = ram_ff[0];
   assign rsp_com1_word = ram_ff[1];
   assign rsp_com2_word = ram_ff[2];
   assign rsp_com3_word = ram_ff[3];

endmodule

`default_nettype wire
